// ===== design/rc_pwm_pulse_capture_top_macros.svh =====
// Assertion macros shared by the RC pulse capture design.
// Depends on nothing; files that assert include it by name.
`ifndef RC_PWM_PULSE_CAPTURE_TOP_MACROS_SVH
`define RC_PWM_PULSE_CAPTURE_TOP_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define RPC_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define RPC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rpc_pkg.sv =====
// Types and constants for the RC pulse width capture block.
// Used by the channel interfaces and the top level.
package rpc_pkg;

    localparam int VALUE_W = 21;
    localparam int WIDTH_W = 16;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 16;
    localparam int TOL_W   = 14;
    localparam int SCALE_W = 12;
    localparam int MULT_W  = 10;
    localparam int PROD_W  = 28;
    localparam int QUO_W   = 26;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [WIDTH_W-1:0] WIDTH_SAT   = 16'd65535;
    localparam logic [MULT_W-1:0]  STEER_UNITS = 10'd1000;
    localparam logic [MULT_W-1:0]  LEGACY_MUL  = 10'd3;
    localparam logic [SCALE_W-1:0] LEGACY_BASE = 12'd980;
    localparam logic [SCALE_W-1:0] LEGACY_DIV  = 12'd17;
    localparam logic [QUO_W-1:0]   POS_LIMIT   = 26'd1048575;
    localparam logic [QUO_W-1:0]   NEG_LIMIT   = 26'd1048576;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 21'h0FFFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN   = 21'h100000;

    localparam logic [15:0] RST_FRAME_PERIOD = 16'd18370;
    localparam logic [13:0] RST_TOLERANCE    = 14'd1300;
    localparam logic [15:0] RST_STEER_MAX    = 16'd2296;
    localparam logic [15:0] RST_STEER_MIN    = 16'd966;
    localparam logic [15:0] RST_THR_MAX      = 16'd1837;
    localparam logic [15:0] RST_THR_MIN      = 16'd874;
    localparam logic [11:0] RST_CENTER       = 12'd1510;
    localparam logic [11:0] RST_PER_STEP     = 12'd350;

    typedef enum logic [1:0] {
        FUNC_EDGE   = 2'd0,
        FUNC_STEER  = 2'd1,
        FUNC_LEGACY = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_FRAME_PERIOD = 3'd0,
        REG_TOLERANCE    = 3'd1,
        REG_STEER_MAX    = 3'd2,
        REG_STEER_MIN    = 3'd3,
        REG_THR_MAX      = 3'd4,
        REG_THR_MIN      = 3'd5,
        REG_CENTER       = 3'd6,
        REG_PER_STEP     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_READ,
        ST_PREP,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } rpc_state_t;

endpackage

// ===== design/rpc_in_if.sv =====
// Input channel carrying edge events and read requests.
// Depends on rpc_pkg for the function code type.
interface rpc_in_if;
    import rpc_pkg::*;

    logic                valid;
    logic                ready;
    func_t               func;
    logic                channel;
    logic                level;
    logic [STAMP_W-1:0]  timestamp_us;

    modport source (output valid, func, channel, level, timestamp_us, input ready);
    modport sink   (input valid, func, channel, level, timestamp_us, output ready);
endinterface

// ===== design/rpc_out_if.sv =====
// Output channel carrying one result per accepted item.
// Depends on rpc_pkg for field widths.
interface rpc_out_if;
    import rpc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic                       available;
    logic [WIDTH_W-1:0]         raw_width;

    modport source (output valid, value, available, raw_width, input ready);
    modport sink   (input valid, value, available, raw_width, output ready);
endinterface

// ===== design/rc_pwm_pulse_capture_top.sv =====
// RC pulse width capture top level; depends on rpc_pkg, rpc_in_if, rpc_out_if.
// Edge events and no-op items pass through the edge state and the done state to the output register.
// Reads pass through read, prep, the 26 steps of the shared restoring divider, fix and done.
// The next item is taken only after the result is loaded, when the block is back in idle;
// a result waits in the done state while the output register is still held.
// Reset clears the timing state, the stored widths and restores the default registers.
`include "rc_pwm_pulse_capture_top_macros.svh"

module rc_pwm_pulse_capture_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  rpc_pkg::cfg_idx_t      cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0] cfg_data,
    rpc_in_if.sink                 in_ch,
    rpc_out_if.source              out_ch
);
    import rpc_pkg::*;

    localparam int CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;

    rpc_state_t state_reg, state_next;

    logic [15:0] frame_period_reg, frame_period_next;
    logic [13:0] tolerance_reg, tolerance_next;
    logic [15:0] steer_max_reg, steer_max_next;
    logic [15:0] steer_min_reg, steer_min_next;
    logic [15:0] thr_max_reg, thr_max_next;
    logic [15:0] thr_min_reg, thr_min_next;
    logic [11:0] center_reg, center_next;
    logic [11:0] per_step_reg, per_step_next;

    logic [TIME_BITS-1:0] rise_time_reg [2];
    logic [TIME_BITS-1:0] rise_time_next [2];
    logic [TIME_BITS-1:0] fall_time_reg [2];
    logic [TIME_BITS-1:0] fall_time_next [2];
    logic [WIDTH_W-1:0]   stored_width_reg [2];
    logic [WIDTH_W-1:0]   stored_width_next [2];
    logic                 width_ready_reg [2];
    logic                 width_ready_next [2];

    func_t                func_reg, func_next;
    logic                 ch_reg, ch_next;
    logic                 level_reg, level_next;
    logic [TIME_BITS-1:0] t_reg, t_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SCALE_W-1:0]   divisor_reg, divisor_next;
    logic                 div_zero_reg, div_zero_next;
    logic                 neg_reg, neg_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [SCALE_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;

    logic [VALUE_W-1:0]   res_value_reg, res_value_next;
    logic                 res_avail_reg, res_avail_next;
    logic [WIDTH_W-1:0]   res_width_reg, res_width_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_avail_reg, out_avail_next;
    logic [WIDTH_W-1:0]   out_width_reg, out_width_next;

    logic [TIME_BITS-1:0] rise_gap;
    logic [16:0]          lo_diff;
    logic [16:0]          hi_sum;
    logic                 in_window;
    logic                 fall_after;
    logic [TIME_BITS-1:0] raw_diff;
    logic [WIDTH_W-1:0]   cap_width;
    logic [WIDTH_W-1:0]   max_w;
    logic [WIDTH_W-1:0]   min_w;
    logic                 cap_ok;
    logic signed [PROD_W-1:0] diff_x;
    logic signed [PROD_W-1:0] mult_x;
    logic [PROD_W-1:0]    prod_mag;
    logic [SCALE_W:0]     rem_shift;
    logic [QUO_W-1:0]     neg_quo;

    assign rise_gap  = t_reg - rise_time_reg[ch_reg];
    assign lo_diff   = {1'b0, frame_period_reg} - {3'b000, tolerance_reg};
    assign hi_sum    = {1'b0, frame_period_reg} + {3'b000, tolerance_reg};
    assign in_window = (lo_diff[16] || (CMP_W'(rise_gap) > CMP_W'(lo_diff)))
                       && (CMP_W'(rise_gap) < CMP_W'(hi_sum));
    assign fall_after = fall_time_reg[ch_reg] > rise_time_reg[ch_reg];
    assign raw_diff  = fall_time_reg[ch_reg] - rise_time_reg[ch_reg];
    assign cap_width = (raw_diff > TIME_BITS'(WIDTH_SAT)) ? WIDTH_SAT
                                                           : raw_diff[WIDTH_W-1:0];
    assign max_w     = ch_reg ? steer_max_reg : thr_max_reg;
    assign min_w     = ch_reg ? steer_min_reg : thr_min_reg;
    assign cap_ok    = !((cap_width >= max_w) || (cap_width < min_w));
    assign prod_mag  = prod_reg[PROD_W-1] ? (PROD_W'(0) - prod_reg) : prod_reg;
    assign rem_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign neg_quo   = QUO_W'(0) - quo_reg;

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value     = out_value_reg;
    assign out_ch.available = out_avail_reg;
    assign out_ch.raw_width = out_width_reg;

    always_comb
    begin
        state_next        = state_reg;
        frame_period_next = frame_period_reg;
        tolerance_next    = tolerance_reg;
        steer_max_next    = steer_max_reg;
        steer_min_next    = steer_min_reg;
        thr_max_next      = thr_max_reg;
        thr_min_next      = thr_min_reg;
        center_next       = center_reg;
        per_step_next     = per_step_reg;
        for (int i = 0; i < 2; i++)
        begin
            rise_time_next[i]    = rise_time_reg[i];
            fall_time_next[i]    = fall_time_reg[i];
            stored_width_next[i] = stored_width_reg[i];
            width_ready_next[i]  = width_ready_reg[i];
        end
        func_next      = func_reg;
        ch_next        = ch_reg;
        level_next     = level_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        divisor_next   = divisor_reg;
        div_zero_next  = div_zero_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        res_value_next = res_value_reg;
        res_avail_next = res_avail_reg;
        res_width_next = res_width_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_avail_next = out_avail_reg;
        out_width_next = out_width_reg;
        diff_x         = '0;
        mult_x         = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_PERIOD: frame_period_next = cfg_data;
                REG_TOLERANCE:    tolerance_next    = cfg_data[TOL_W-1:0];
                REG_STEER_MAX:    steer_max_next    = cfg_data;
                REG_STEER_MIN:    steer_min_next    = cfg_data;
                REG_THR_MAX:      thr_max_next      = cfg_data;
                REG_THR_MIN:      thr_min_next      = cfg_data;
                REG_CENTER:       center_next       = cfg_data[SCALE_W-1:0];
                REG_PER_STEP:     per_step_next     = cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    func_next  = in_ch.func;
                    ch_next    = in_ch.channel;
                    level_next = in_ch.level;
                    t_next     = TIME_BITS'(in_ch.timestamp_us);
                    case (in_ch.func) inside
                        FUNC_STEER, FUNC_LEGACY: state_next = ST_READ;
                        default:                 state_next = ST_EDGE;
                    endcase
                end
            end
            ST_EDGE:
            begin
                if (func_reg == FUNC_EDGE)
                begin
                    if (level_reg)
                    begin
                        if (in_window && fall_after && !width_ready_reg[ch_reg])
                        begin
                            stored_width_next[ch_reg] = cap_width;
                            width_ready_next[ch_reg]  = cap_ok;
                        end
                        rise_time_next[ch_reg] = t_reg;
                    end
                    else if (rise_time_reg[ch_reg] != '0)
                    begin
                        fall_time_next[ch_reg] = t_reg;
                    end
                end
                res_value_next = '0;
                res_avail_next = width_ready_next[ch_reg];
                res_width_next = stored_width_next[ch_reg];
                state_next     = ST_DONE;
            end
            ST_READ:
            begin
                if (func_reg == FUNC_STEER)
                begin
                    diff_x = $signed({12'd0, stored_width_reg[ch_reg]})
                             - $signed({16'd0, center_reg});
                    mult_x = $signed({18'd0, STEER_UNITS});
                    divisor_next = per_step_reg;
                end
                else
                begin
                    diff_x = $signed({12'd0, stored_width_reg[ch_reg]})
                             - $signed({16'd0, LEGACY_BASE});
                    mult_x = $signed({18'd0, LEGACY_MUL});
                    divisor_next = LEGACY_DIV;
                end
                prod_next      = diff_x * mult_x;
                div_zero_next  = (divisor_next == '0);
                res_avail_next = width_ready_reg[ch_reg];
                res_width_next = stored_width_reg[ch_reg];
                width_ready_next[ch_reg] = 1'b0;
                state_next     = ST_PREP;
            end
            ST_PREP:
            begin
                neg_next     = prod_reg[PROD_W-1];
                quo_next     = prod_mag[QUO_W-1:0];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, divisor_reg})
                begin
                    rem_next = SCALE_W'(rem_shift - {1'b0, divisor_reg});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[SCALE_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (div_zero_reg)
                begin
                    res_value_next = '0;
                end
                else if (neg_reg)
                begin
                    res_value_next = (quo_reg > NEG_LIMIT) ? VALUE_MIN
                                                           : neg_quo[VALUE_W-1:0];
                end
                else
                begin
                    res_value_next = (quo_reg > POS_LIMIT) ? VALUE_MAX
                                                           : quo_reg[VALUE_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_avail_next = res_avail_reg;
                    out_width_next = res_width_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg <= RST_FRAME_PERIOD;
            tolerance_reg    <= RST_TOLERANCE;
            steer_max_reg    <= RST_STEER_MAX;
            steer_min_reg    <= RST_STEER_MIN;
            thr_max_reg      <= RST_THR_MAX;
            thr_min_reg      <= RST_THR_MIN;
            center_reg       <= RST_CENTER;
            per_step_reg     <= RST_PER_STEP;
            for (int i = 0; i < 2; i++)
            begin
                rise_time_reg[i]    <= '0;
                fall_time_reg[i]    <= '0;
                stored_width_reg[i] <= '0;
                width_ready_reg[i]  <= 1'b0;
            end
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_period_reg <= frame_period_next;
            tolerance_reg    <= tolerance_next;
            steer_max_reg    <= steer_max_next;
            steer_min_reg    <= steer_min_next;
            thr_max_reg      <= thr_max_next;
            thr_min_reg      <= thr_min_next;
            center_reg       <= center_next;
            per_step_reg     <= per_step_next;
            for (int i = 0; i < 2; i++)
            begin
                rise_time_reg[i]    <= rise_time_next[i];
                fall_time_reg[i]    <= fall_time_next[i];
                stored_width_reg[i] <= stored_width_next[i];
                width_ready_reg[i]  <= width_ready_next[i];
            end
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        ch_reg        <= ch_next;
        level_reg     <= level_next;
        t_reg         <= t_next;
        prod_reg      <= prod_next;
        divisor_reg   <= divisor_next;
        div_zero_reg  <= div_zero_next;
        neg_reg       <= neg_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        res_value_reg <= res_value_next;
        res_avail_reg <= res_avail_next;
        res_width_reg <= res_width_next;
        out_value_reg <= out_value_next;
        out_avail_reg <= out_avail_next;
        out_width_reg <= out_width_next;
    end

    // With a nonzero divisor, the divider only ever holds a remainder below the divisor.
    `RPC_ASSERT_SAME(a_rem_below_div, clk, rst_n,
                     (state_reg == ST_DIV) && !div_zero_reg, rem_reg < divisor_reg,
                     "divider remainder not below divisor")
    `RPC_ASSERT_SAME(a_cnt_bound, clk, rst_n,
                     state_reg == ST_DIV, div_cnt_reg < CNT_W'(DIV_STEPS),
                     "divider step count overran")
    `RPC_ASSERT_NEXT(a_read_clears, clk, rst_n,
                     state_reg == ST_READ, !width_ready_reg[ch_reg],
                     "read did not clear the available mark")
    `RPC_ASSERT_NEXT(a_done_loads, clk, rst_n,
                     (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready),
                     out_valid_reg && (state_reg == ST_IDLE),
                     "finished result not loaded into output register")

endmodule
